/* rtl/core/tsca_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables for the tempo-synced chord arpeggiator.
package tsca_pkg;

    localparam int BLOCK_SAMPLES_DEF = 64;
    localparam int MAX_NOTES_DEF     = 16;
    localparam int ORDER_DEPTH_DEF   = 40;
    localparam int CFG_W             = 16;

    localparam logic [6:0]  POS_REARMED   = 7'd127;
    localparam logic [4:0]  REST_CODE     = 5'd31;
    localparam logic [4:0]  MODE_INVALID  = 5'd31;
    localparam logic [3:0]  LAST_CHORD    = 4'd13;
    localparam logic [21:0] TICK_DIVIDEND = 22'd2880000;
    localparam logic [4:0]  DIV_STEPS_M1  = 5'd21;
    localparam logic [15:0] MIN_BPM       = 16'd20;
    localparam logic [15:0] DEF_BPM       = 16'd120;
    localparam logic [13:0] OCTAVE_Q8     = 14'd3072;

    localparam logic [3:0] MODE_OFF           = 4'd0;
    localparam logic [3:0] MODE_UP            = 4'd1;
    localparam logic [3:0] MODE_DOWN          = 4'd2;
    localparam logic [3:0] MODE_UP_DOWN       = 4'd3;
    localparam logic [3:0] MODE_DOWN_UP       = 4'd4;
    localparam logic [3:0] MODE_UP_PAUSE_DOWN = 4'd5;
    localparam logic [3:0] MODE_UP_DOWN_PAUSE = 4'd6;
    localparam logic [3:0] MODE_DOWN_PAUSE_UP = 4'd7;
    localparam logic [3:0] MODE_DOWN_UP_PAUSE = 4'd8;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } tsca_op_t;

    typedef enum logic [2:0] {
        CFG_PATTERN_MODE = 3'd0,
        CFG_NOTE_SOURCE  = 3'd1,
        CFG_STEP_RATE    = 3'd2,
        CFG_OCTAVE_SPAN  = 3'd3,
        CFG_TEMPO_BPM    = 3'd4,
        CFG_CHORD_SELECT = 3'd5
    } tsca_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_DIV,
        ST_ACC,
        ST_CMP,
        ST_READ,
        ST_PITCH,
        ST_EMIT
    } tsca_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] root_pitch;
    } tsca_in_t;

    typedef struct packed {
        logic [15:0] note_pitch;
        logic        strum;
    } tsca_out_t;

    function automatic logic [2:0] chord_size(input logic [3:0] row);
        logic [2:0] sz;
        begin
            unique case (row)
                4'd0:                  sz = 3'd2;
                4'd1, 4'd2, 4'd3:      sz = 3'd3;
                4'd10:                 sz = 3'd3;
                default:               sz = 3'd4;
            endcase
            return sz;
        end
    endfunction

    function automatic logic [12:0] chord_offset(input logic [3:0] row, input logic [1:0] idx);
        logic [3:0][12:0] tones;
        begin
            unique case (row)
                4'd0:    tones = {13'd0,    13'd0,    13'd3072, 13'd0};
                4'd1:    tones = {13'd0,    13'd3072, 13'd1792, 13'd0};
                4'd2:    tones = {13'd0,    13'd1792, 13'd1280, 13'd0};
                4'd3:    tones = {13'd0,    13'd1792, 13'd768,  13'd0};
                4'd4:    tones = {13'd2560, 13'd1792, 13'd768,  13'd0};
                4'd5:    tones = {13'd3584, 13'd1792, 13'd768,  13'd0};
                4'd6:    tones = {13'd4352, 13'd1792, 13'd768,  13'd0};
                4'd7:    tones = {13'd2304, 13'd1792, 13'd1024, 13'd0};
                4'd8:    tones = {13'd3584, 13'd1792, 13'd1024, 13'd0};
                4'd9:    tones = {13'd2816, 13'd1792, 13'd1024, 13'd0};
                4'd10:   tones = {13'd0,    13'd1792, 13'd1024, 13'd0};
                4'd11:   tones = {13'd3840, 13'd2560, 13'd1280, 13'd0};
                4'd12:   tones = {13'd2481, 13'd1797, 13'd988,  13'd0};
                default: tones = {13'd1843, 13'd1229, 13'd614,  13'd0};
            endcase
            return tones[idx];
        end
    endfunction

    function automatic logic [3:0] rate_div(input logic [2:0] sel);
        logic [3:0] d;
        begin
            unique case (sel)
                3'd0:    d = 4'd1;
                3'd1:    d = 4'd2;
                3'd2:    d = 4'd3;
                3'd3:    d = 4'd4;
                3'd4:    d = 4'd6;
                3'd5:    d = 4'd8;
                default: d = 4'd4;
            endcase
            return d;
        end
    endfunction

    function automatic logic [5:0] order_len(input logic [3:0] mode, input logic [4:0] n);
        logic [5:0] nn;
        logic [5:0] l3;
        logic [5:0] len;
        begin
            nn = {1'b0, n};
            l3 = (n >= 5'd3) ? 6'((nn << 1) - 6'd2) : nn;
            unique case (mode)
                MODE_UP, MODE_DOWN:                     len = nn;
                MODE_UP_DOWN, MODE_DOWN_UP:             len = l3;
                MODE_UP_PAUSE_DOWN, MODE_DOWN_PAUSE_UP: len = 6'((nn << 1) + 6'd1);
                MODE_UP_DOWN_PAUSE, MODE_DOWN_UP_PAUSE: len = 6'(l3 + 6'd1);
                default:                                len = 6'd1;
            endcase
            return len;
        end
    endfunction

    function automatic logic [4:0] order_code(input logic [3:0] mode, input logic [4:0] n,
                                              input logic [5:0] j);
        logic [5:0] nn;
        logic [5:0] l3;
        logic [5:0] up_dn;
        logic [5:0] dn_up;
        logic [5:0] code;
        logic       rest;
        begin
            nn    = {1'b0, n};
            l3    = (n >= 5'd3) ? 6'((nn << 1) - 6'd2) : nn;
            up_dn = (j < nn) ? j : 6'((nn << 1) - 6'd2 - j);
            dn_up = (j < nn) ? 6'(nn - 6'd1 - j) : 6'(j - nn + 6'd1);
            rest  = 1'b0;
            unique case (mode)
                MODE_UP:      code = j;
                MODE_DOWN:    code = 6'(nn - 6'd1 - j);
                MODE_UP_DOWN: code = up_dn;
                MODE_DOWN_UP: code = dn_up;
                MODE_UP_PAUSE_DOWN:
                begin
                    code = (j < nn) ? j : 6'((nn << 1) - j);
                    rest = (j == nn);
                end
                MODE_UP_DOWN_PAUSE:
                begin
                    code = up_dn;
                    rest = (j >= l3);
                end
                MODE_DOWN_PAUSE_UP:
                begin
                    code = (j < nn) ? 6'(nn - 6'd1 - j) : 6'(j - nn - 6'd1);
                    rest = (j == nn);
                end
                MODE_DOWN_UP_PAUSE:
                begin
                    code = dn_up;
                    rest = (j >= l3);
                end
                default:      code = 6'd0;
            endcase
            return rest ? REST_CODE : code[4:0];
        end
    endfunction

endpackage

/* rtl/core/tempo_synced_chord_arpeggiator.sv */
`timescale 1ns / 1ps
// Tempo-synced chord arpeggiator: note list, step order, step timer and strum.
//
//   channel   direction  handshake              payload
//   cmd       to block   cmd_valid / cmd_stall  tsca_in_t  (op, root_pitch)
//   res       from block res_valid / res_stall  tsca_out_t (note_pitch, strum)
//   cfg       to block   cfg_we                 cfg_index, cfg_data
//
// Note on, note off and unused ops leave the block idle; a tick with the arpeggiator
// off goes straight to the emit state. An arpeggiated tick runs the 22-step serial
// step-length divider, then the accumulate, compare, read and pitch states, after
// one write per order entry (up to 2*MAX_NOTES+1) when the step order is rebuilt.
// Reset is asynchronous; the order memory holds no reset and is always rebuilt first.
// A result waits in the output register under res_stall while the next request is taken.
module tempo_synced_chord_arpeggiator
    import tsca_pkg::*;
#(
    parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
    parameter int MAX_NOTES     = MAX_NOTES_DEF,
    parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  tsca_in_t         cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output tsca_out_t        res,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(ORDER_DEPTH);

    tsca_state_t state_reg, state_next;

    logic [3:0]  pattern_mode_reg;
    logic        note_source_reg;
    logic [2:0]  step_rate_reg;
    logic [2:0]  octave_span_reg;
    logic [15:0] tempo_bpm_reg;
    logic [3:0]  chord_select_reg;

    logic        gate_held_reg;
    logic        previous_gate_reg;
    logic [6:0]  step_position_reg;
    logic [31:0] sample_acc_reg;
    logic [6:0]  order_length_reg;
    logic [4:0]  built_count_reg;
    logic [4:0]  built_mode_reg;
    logic        res_valid_reg;

    logic [14:0] root_reg;
    logic [6:0]  cnt_reg;
    logic [18:0] rem_reg;
    logic [21:0] quot_reg;
    logic        fire_reg;
    logic [4:0]  code_reg;
    logic [15:0] res_pitch_reg;
    logic        res_strum_reg;
    tsca_out_t   out_reg;

    logic [4:0]  order_mem [ORDER_DEPTH];

    logic        cmd_accept;
    logic        emit_load;
    logic        mem_we;
    logic        mem_re;

    logic [2:0]  oct;
    logic [3:0]  row;
    logic [2:0]  chord_sz;
    logic [4:0]  n_chord;
    logic [4:0]  n_notes;
    logic        arp_on;
    logic        need_build;
    logic [5:0]  len_raw;
    logic [6:0]  len_cap;
    logic        build_done;

    logic [15:0] bpm_eff;
    logic [18:0] divisor;
    logic [19:0] shifted;
    logic [19:0] div_ext;
    logic        div_ge;
    logic [18:0] rem_next;
    logic        div_done;

    logic [21:0] step_len;
    logic [32:0] acc_diff;
    logic [6:0]  pos_inc;
    logic [6:0]  pos_adv;

    logic        hit;
    logic [7:0]  third_prod;
    logic [3:0]  oct_idx;
    logic [1:0]  tone_idx;
    logic [1:0]  oct_sel;
    logic [12:0] tone;
    logic [13:0] offset;
    logic [16:0] pitch_sum;
    logic [15:0] pitch_sat;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_valid  = res_valid_reg;
    assign res        = out_reg;

    // note list size from configuration
    always_comb
    begin
        if (octave_span_reg == 3'd0)
        begin
            oct = 3'd1;
        end
        else if (octave_span_reg > 3'd4)
        begin
            oct = 3'd4;
        end
        else
        begin
            oct = octave_span_reg;
        end
        row      = (chord_select_reg > LAST_CHORD) ? LAST_CHORD : chord_select_reg;
        chord_sz = chord_size(row);
        n_chord  = 5'(5'(oct) * 5'(chord_sz));
        if (note_source_reg)
        begin
            n_notes = {2'b00, oct};
        end
        else
        begin
            n_notes = (n_chord > 5'(MAX_NOTES)) ? 5'(MAX_NOTES) : n_chord;
        end
    end

    assign arp_on     = (pattern_mode_reg != MODE_OFF) && gate_held_reg;
    assign need_build = (n_notes != built_count_reg) || ({1'b0, pattern_mode_reg} != built_mode_reg);
    assign len_raw    = order_len(pattern_mode_reg, n_notes);
    assign len_cap    = ({1'b0, len_raw} > 7'(ORDER_DEPTH)) ? 7'(ORDER_DEPTH) : {1'b0, len_raw};
    assign build_done = (cnt_reg == 7'(len_cap - 7'd1));

    // serial restoring divider for the step length
    assign bpm_eff  = (tempo_bpm_reg >= MIN_BPM) ? tempo_bpm_reg : DEF_BPM;
    assign divisor  = 19'(20'(bpm_eff) * 20'(rate_div(step_rate_reg)));
    assign shifted  = {rem_reg, TICK_DIVIDEND[cnt_reg[4:0]]};
    assign div_ext  = {1'b0, divisor};
    assign div_ge   = (shifted >= div_ext);
    assign rem_next = div_ge ? 19'(shifted - div_ext) : shifted[18:0];
    assign div_done = (cnt_reg[4:0] == 5'd0);

    assign step_len = (quot_reg == 22'd0) ? 22'd1 : quot_reg;
    assign acc_diff = {1'b0, sample_acc_reg} - {11'b0, step_len};
    assign pos_inc  = 7'(step_position_reg + 7'd1);
    assign pos_adv  = (pos_inc >= order_length_reg) ? 7'd0 : pos_inc;

    // note pitch for the step code
    always_comb
    begin
        hit        = (code_reg < n_notes);
        third_prod = 8'(8'(code_reg[3:0]) * 8'd11);
        unique case (chord_sz)
            3'd2:
            begin
                oct_idx  = {1'b0, code_reg[3:1]};
                tone_idx = {1'b0, code_reg[0]};
            end
            3'd3:
            begin
                oct_idx  = {1'b0, third_prod[7:5]};
                tone_idx = 2'(code_reg[3:0] - (oct_idx << 1) - oct_idx);
            end
            default:
            begin
                oct_idx  = {2'b00, code_reg[3:2]};
                tone_idx = code_reg[1:0];
            end
        endcase
        oct_sel   = note_source_reg ? code_reg[1:0] : oct_idx[1:0];
        tone      = note_source_reg ? 13'd0 : chord_offset(row, tone_idx);
        offset    = 14'(14'(tone) + 14'(14'(oct_sel) * OCTAVE_Q8));
        pitch_sum = 17'(root_reg) + 17'(offset);
        pitch_sat = pitch_sum[16] ? 16'hFFFF : pitch_sum[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept && (cmd.op == OP_TICK))
                begin
                    if (!arp_on)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (need_build)
                    begin
                        state_next = ST_BUILD;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_BUILD:
            begin
                if (build_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_READ;
            ST_READ:  state_next = ST_PITCH;
            ST_PITCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = (state_reg != ST_IDLE);
        emit_load = (state_reg == ST_EMIT) && (!res_valid_reg || !res_stall);
        mem_we    = (state_reg == ST_BUILD);
        mem_re    = (state_reg == ST_READ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pattern_mode_reg  <= MODE_OFF;
            note_source_reg   <= 1'b0;
            step_rate_reg     <= 3'd3;
            octave_span_reg   <= 3'd1;
            tempo_bpm_reg     <= DEF_BPM;
            chord_select_reg  <= 4'd0;
            gate_held_reg     <= 1'b0;
            previous_gate_reg <= 1'b0;
            step_position_reg <= POS_REARMED;
            sample_acc_reg    <= 32'd0;
            order_length_reg  <= 7'd0;
            built_count_reg   <= 5'd0;
            built_mode_reg    <= MODE_INVALID;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_MODE:
                    begin
                        pattern_mode_reg <= cfg_data[3:0];
                        built_mode_reg   <= MODE_INVALID;
                        if (cfg_data[3:0] == MODE_OFF)
                        begin
                            step_position_reg <= POS_REARMED;
                        end
                    end
                    CFG_NOTE_SOURCE:
                    begin
                        note_source_reg <= cfg_data[0];
                        built_count_reg <= 5'd0;
                    end
                    CFG_STEP_RATE:   step_rate_reg <= cfg_data[2:0];
                    CFG_OCTAVE_SPAN:
                    begin
                        octave_span_reg <= cfg_data[2:0];
                        built_count_reg <= 5'd0;
                    end
                    CFG_TEMPO_BPM:
                    begin
                        if (cfg_data != 16'd0)
                        begin
                            tempo_bpm_reg <= cfg_data;
                        end
                    end
                    CFG_CHORD_SELECT: chord_select_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        case (cmd.op)
                            OP_NOTE_ON:
                            begin
                                gate_held_reg     <= 1'b1;
                                step_position_reg <= POS_REARMED;
                                sample_acc_reg    <= 32'd0;
                            end
                            OP_NOTE_OFF: gate_held_reg <= 1'b0;
                            OP_TICK:
                            begin
                                if (!arp_on)
                                begin
                                    previous_gate_reg <= gate_held_reg;
                                    if (!gate_held_reg)
                                    begin
                                        step_position_reg <= POS_REARMED;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_BUILD:
                begin
                    if (build_done)
                    begin
                        order_length_reg <= len_cap;
                        built_count_reg  <= n_notes;
                        built_mode_reg   <= {1'b0, pattern_mode_reg};
                        if ((step_position_reg != POS_REARMED) && (step_position_reg >= len_cap))
                        begin
                            step_position_reg <= POS_REARMED;
                        end
                    end
                end
                ST_ACC:
                begin
                    if (step_position_reg == POS_REARMED)
                    begin
                        step_position_reg <= 7'd0;
                        sample_acc_reg    <= 32'd0;
                    end
                    else
                    begin
                        sample_acc_reg <= 32'(sample_acc_reg + 32'(BLOCK_SAMPLES));
                    end
                end
                ST_CMP:
                begin
                    if (!fire_reg && !acc_diff[32])
                    begin
                        sample_acc_reg    <= acc_diff[31:0];
                        step_position_reg <= pos_adv;
                    end
                end
                ST_PITCH: previous_gate_reg <= gate_held_reg;
                default: ;
            endcase

            if (emit_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                root_reg      <= cmd.root_pitch;
                rem_reg       <= 19'd0;
                cnt_reg       <= need_build ? 7'd0 : 7'(DIV_STEPS_M1);
                res_pitch_reg <= {1'b0, cmd.root_pitch};
                res_strum_reg <= gate_held_reg && !previous_gate_reg;
            end
            ST_BUILD:
            begin
                rem_reg <= 19'd0;
                cnt_reg <= build_done ? 7'(DIV_STEPS_M1) : 7'(cnt_reg + 7'd1);
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[20:0], div_ge};
                cnt_reg  <= 7'(cnt_reg - 7'd1);
            end
            ST_ACC:  fire_reg <= (step_position_reg == POS_REARMED);
            ST_CMP:
            begin
                if (!acc_diff[32])
                begin
                    fire_reg <= 1'b1;
                end
            end
            ST_PITCH:
            begin
                res_pitch_reg <= hit ? pitch_sat : {1'b0, root_reg};
                res_strum_reg <= hit && fire_reg;
            end
            default: ;
        endcase

        if (emit_load)
        begin
            out_reg.note_pitch <= res_pitch_reg;
            out_reg.strum      <= res_strum_reg;
        end
    end

    // step order memory: one write port for the rebuild sweep, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            order_mem[cnt_reg[AW-1:0]] <= order_code(pattern_mode_reg, n_notes, cnt_reg[5:0]);
        end
        if (mem_re)
        begin
            code_reg <= order_mem[step_position_reg[AW-1:0]];
        end
    end

endmodule

/* rtl/core/tsca_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the arpeggiator and the bind that attaches them.
module tsca_checker
    import tsca_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input tsca_in_t  cmd,
    input logic      res_valid,
    input logic      res_stall,
    input tsca_out_t res
);

    // non-tick requests finish in the cycle they are taken
    a_gate_op_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (cmd.op != OP_TICK)) |=> !cmd_stall)
        else $error("block busy after a non-tick request");

    // a fresh result comes with the block ready again
    a_result_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !cmd_stall)
        else $error("new result while the block is still busy");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result dropped or changed");

endmodule

bind tempo_synced_chord_arpeggiator tsca_checker u_tsca_checker (.*);
